[sv/expert_major_pair_bucketing_top_assert.svh]
// assertion macros for the pair bucketing block
// used by expert_major_pair_bucketing_top, no other dependencies
`ifndef EXPERT_MAJOR_PAIR_BUCKETING_TOP_ASSERT_SVH
`define EXPERT_MAJOR_PAIR_BUCKETING_TOP_ASSERT_SVH

// same-cycle implication
`define EMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/emp_pkg.sv]
// shared types and constants of the pair bucketing block
// no dependencies
`timescale 1ns / 1ps
package emp_pkg;

  localparam int MAX_PAIRS   = 64;
  localparam int MAX_EXPERTS = 256;

  localparam logic [2:0] REG_EXPERT_COUNT    = 3'd0;
  localparam logic [2:0] REG_EXPERTS_PER_ROW = 3'd1;
  localparam logic [2:0] REG_ROW_COUNT       = 3'd2;
  localparam logic [2:0] REG_WIDTH_MASK      = 3'd3;
  localparam logic [2:0] REG_TC_MINIMUM      = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_CFG  = 2'd1;
  localparam logic [1:0] ST_PAIR = 2'd2;

  typedef struct packed {
    logic [8:0]  n_experts;
    logic [8:0]  per_row;
    logic [5:0]  n_rows;
    logic [62:0] width_mask;
    logic [5:0]  tc_minimum;
    logic [14:0] pair_total;
    logic        valid;
  } cfg_t;

endpackage

[sv/emp_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module emp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/emp_cfg.sv]
// apb register file and configuration check
// depends on emp_pkg
`timescale 1ns / 1ps
module emp_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  output emp_pkg::cfg_t cfg_o
);
  import emp_pkg::*;

  logic [8:0]  ec_q, epr_q;
  logic [5:0]  rc_q, tcm_q;
  logic [62:0] wm_q;
  logic        wr;
  logic [2:0]  idx;
  logic [14:0] total;
  logic [63:0] wm_ext;
  logic        ok;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_q  <= 9'd1;
      epr_q <= 9'd1;
      rc_q  <= 6'd1;
      wm_q  <= 63'd2;
      tcm_q <= 6'd0;
    end else if (wr) begin
      case (idx)
        REG_EXPERT_COUNT:    ec_q  <= pwdata[8:0];
        REG_EXPERTS_PER_ROW: epr_q <= pwdata[8:0];
        REG_ROW_COUNT:       rc_q  <= pwdata[5:0];
        REG_WIDTH_MASK:      wm_q  <= pwdata[62:0];
        REG_TC_MINIMUM:      tcm_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_EXPERT_COUNT:    prdata = {55'd0, ec_q};
      REG_EXPERTS_PER_ROW: prdata = {55'd0, epr_q};
      REG_ROW_COUNT:       prdata = {58'd0, rc_q};
      REG_WIDTH_MASK:      prdata = {1'b0, wm_q};
      REG_TC_MINIMUM:      prdata = {58'd0, tcm_q};
      default:             prdata = '0;
    endcase
  end

  assign total  = {9'd0, rc_q} * {6'd0, epr_q};
  assign wm_ext = {1'b0, wm_q};

  always_comb begin
    ok = 1'b1;
    if (ec_q == 9'd0 || ec_q > 9'(MAX_EXPERTS)) ok = 1'b0;
    if (epr_q == 9'd0 || epr_q > ec_q) ok = 1'b0;
    if (rc_q == 6'd0 || rc_q == 6'd63) ok = 1'b0;
    if (!wm_q[1] || wm_q[0]) ok = 1'b0;
    if (!wm_ext[rc_q]) ok = 1'b0;
    if (tcm_q != 6'd0 && (tcm_q == 6'd63 || !wm_ext[tcm_q])) ok = 1'b0;
    if (total > 15'(MAX_PAIRS)) ok = 1'b0;
  end

  assign cfg_o = '{n_experts: ec_q, per_row: epr_q, n_rows: rc_q,
                   width_mask: wm_q, tc_minimum: tcm_q, pair_total: total, valid: ok};

endmodule

[sv/expert_major_pair_bucketing_top.sv]
// top level: pair load, counting sort sequencer and result register
// depends on emp_pkg, emp_cfg, emp_ram and the assertion macro header
`timescale 1ns / 1ps
// Routed pairs are taken one per cycle while the block is idle and its output
// register is empty, so the pairs of a run can arrive back to back. After the
// last pair of a run the sequencer searches the tile width by shifting the
// width mask, counts buckets by reading each pair and its population, computes
// bucket offsets over all 256 experts plus, for each eligible bucket when the
// tile width is nonzero, subtracting the tile width until the remainder is
// below it, then scatters each pair and emits each pair while the receiver
// keeps up; each ram has a single read port with registered read data. Input
// is not taken until the last result has left the output register. Error
// results appear in the cycle after the transaction that reveals them.
module expert_major_pair_bucketing_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // expert_index, route_weight
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // status, expert_id, bucket_start,
                                       // bucket_population, source_pair,
                                       // token_row, pair_weight, nonempty_buckets,
                                       // max_population, eligible_pairs,
                                       // pad_rows, zero pad
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import emp_pkg::*;

  typedef struct packed {
    logic [11:0] tail;
    logic [6:0]  elig;
    logic [6:0]  maxp;
    logic [6:0]  bcnt;
    logic [31:0] weight;
    logic [5:0]  row;
    logic [5:0]  pair;
    logic [6:0]  pop;
    logic [5:0]  start;
    logic [7:0]  expert;
    logic [1:0]  status;
    logic        last;
  } out_t;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_WID      = 4'd1;
  localparam logic [3:0] S_CNT_RD   = 4'd2;
  localparam logic [3:0] S_CNT_POP  = 4'd3;
  localparam logic [3:0] S_CNT_WR   = 4'd4;
  localparam logic [3:0] S_PFX_RD   = 4'd5;
  localparam logic [3:0] S_PFX_DAT  = 4'd6;
  localparam logic [3:0] S_MOD      = 4'd7;
  localparam logic [3:0] S_SCT_RD   = 4'd8;
  localparam logic [3:0] S_SCT_CUR  = 4'd9;
  localparam logic [3:0] S_SCT_WR   = 4'd10;
  localparam logic [3:0] S_EMT_SLOT = 4'd11;
  localparam logic [3:0] S_EMT_PAIR = 4'd12;
  localparam logic [3:0] S_EMT_BKT  = 4'd13;
  localparam logic [3:0] S_EMT_OUT  = 4'd14;

  cfg_t cfg;

  emp_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  logic [3:0]   state_q;
  logic [6:0]   pl_q, n_q, p_q, k_q, cursor_q, r_q, bcnt_q, maxp_q, elig_q;
  logic         err_q, out_vld_q;
  logic [255:0] pop_vld_q;
  logic [62:0]  m_q;
  logic [5:0]   wid_q, row_q;
  logic [8:0]   col_q;
  logic [7:0]   e_q;
  logic [31:0]  w_q;
  logic [11:0]  tail_q;
  out_t         out_q;

  logic         s_acc, pair_err, last_pair, last_emit;
  logic [6:0]   pl_inc, popv;
  logic [39:0]  pair_rd;
  logic [6:0]   pop_rd, cur_rd;
  logic [11:0]  slot_rd;
  logic         pop_we, cur_we, slot_we, pair_we;
  logic [5:0]   pair_ra;
  logic [7:0]   pop_ra, cur_ra;
  logic [6:0]   cur_wd;

  assign s_axis_tready = (state_q == S_IDLE) && !out_vld_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign pl_inc        = pl_q + 7'd1;
  assign pair_err      = ({1'b0, s_axis_tdata[7:0]} >= cfg.n_experts) ||
                         (s_axis_tdata[38:31] == 8'hFF);
  assign popv          = pop_vld_q[e_q] ? pop_rd : 7'd0;
  assign last_pair     = (p_q == n_q - 7'd1);
  assign last_emit     = (k_q == n_q - 7'd1);

  assign pair_we = s_acc && cfg.valid && (pl_q < 7'(MAX_PAIRS));
  assign pair_ra = (state_q == S_EMT_PAIR) ? slot_rd[5:0] : p_q[5:0];
  assign pop_ra  = (state_q == S_CNT_POP || state_q == S_EMT_BKT) ? pair_rd[7:0] : e_q;
  assign cur_ra  = (state_q == S_SCT_CUR || state_q == S_EMT_BKT) ? pair_rd[7:0] : e_q;
  assign pop_we  = (state_q == S_CNT_WR);
  assign cur_we  = (state_q == S_PFX_DAT) || (state_q == S_SCT_WR);
  assign cur_wd  = (state_q == S_PFX_DAT) ? cursor_q : cur_rd + 7'd1;
  assign slot_we = (state_q == S_SCT_WR);

  emp_ram #(.Width(40), .Depth(MAX_PAIRS)) u_pair_ram (
    .clk_i, .we_i(pair_we), .waddr_i(pl_q[5:0]),
    .wdata_i({s_axis_tdata[39:8], s_axis_tdata[7:0]}),
    .raddr_i(pair_ra), .rdata_o(pair_rd)
  );

  emp_ram #(.Width(7), .Depth(MAX_EXPERTS)) u_pop_ram (
    .clk_i, .we_i(pop_we), .waddr_i(e_q), .wdata_i(popv + 7'd1),
    .raddr_i(pop_ra), .rdata_o(pop_rd)
  );

  emp_ram #(.Width(7), .Depth(MAX_EXPERTS)) u_cur_ram (
    .clk_i, .we_i(cur_we), .waddr_i(e_q), .wdata_i(cur_wd),
    .raddr_i(cur_ra), .rdata_o(cur_rd)
  );

  emp_ram #(.Width(12), .Depth(MAX_PAIRS)) u_slot_ram (
    .clk_i, .we_i(slot_we), .waddr_i(cur_rd[5:0]), .wdata_i({row_q, p_q[5:0]}),
    .raddr_i(k_q[5:0]), .rdata_o(slot_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pl_q      <= '0;
      err_q     <= 1'b0;
      pop_vld_q <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
      n_q <= '0; p_q <= '0; k_q <= '0; cursor_q <= '0; r_q <= '0;
      bcnt_q <= '0; maxp_q <= '0; elig_q <= '0; tail_q <= '0;
      m_q <= '0; wid_q <= '0; row_q <= '0; col_q <= '0; e_q <= '0; w_q <= '0;
    end else begin
      if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            if (!cfg.valid) begin
              out_q     <= '{status: ST_CFG, last: 1'b1, default: '0};
              out_vld_q <= 1'b1;
              pl_q      <= '0;
              err_q     <= 1'b0;
              pop_vld_q <= '0;
            end else if ({8'd0, pl_inc} < cfg.pair_total) begin
              pl_q  <= pl_inc;
              err_q <= err_q || pair_err;
            end else if (err_q || pair_err) begin
              out_q     <= '{status: ST_PAIR, last: 1'b1, default: '0};
              out_vld_q <= 1'b1;
              pl_q      <= '0;
              err_q     <= 1'b0;
              pop_vld_q <= '0;
            end else begin
              pl_q    <= pl_inc;
              n_q     <= (pl_inc > 7'(MAX_PAIRS)) ? 7'(MAX_PAIRS) : pl_inc;
              m_q     <= cfg.width_mask;
              wid_q   <= '0;
              state_q <= S_WID;
            end
          end
        end
        S_WID: begin
          if ((m_q >> 1) != 63'd0) begin
            wid_q <= wid_q + 6'd1;
            m_q   <= m_q >> 1;
          end else begin
            p_q     <= '0;
            state_q <= S_CNT_RD;
          end
        end
        S_CNT_RD:  state_q <= S_CNT_POP;
        S_CNT_POP: begin
          e_q     <= pair_rd[7:0];
          state_q <= S_CNT_WR;
        end
        S_CNT_WR: begin
          pop_vld_q[e_q] <= 1'b1;
          if (last_pair) begin
            e_q <= '0; cursor_q <= '0; bcnt_q <= '0; maxp_q <= '0;
            elig_q <= '0; tail_q <= '0;
            state_q <= S_PFX_RD;
          end else begin
            p_q     <= p_q + 7'd1;
            state_q <= S_CNT_RD;
          end
        end
        S_PFX_RD: state_q <= S_PFX_DAT;
        S_PFX_DAT: begin
          cursor_q <= cursor_q + popv;
          if (popv != 7'd0) begin
            bcnt_q <= bcnt_q + 7'd1;
            if (popv > maxp_q) maxp_q <= popv;
          end
          if (popv != 7'd0 && cfg.tc_minimum != 6'd0 && popv >= {1'b0, cfg.tc_minimum}) begin
            elig_q <= elig_q + popv;
          end
          if (popv != 7'd0 && cfg.tc_minimum != 6'd0 &&
              popv >= {1'b0, cfg.tc_minimum} && wid_q != 6'd0) begin
            r_q     <= popv;
            state_q <= S_MOD;
          end else if (e_q == 8'hFF) begin
            p_q <= '0; row_q <= '0; col_q <= '0;
            state_q <= S_SCT_RD;
          end else begin
            e_q     <= e_q + 8'd1;
            state_q <= S_PFX_RD;
          end
        end
        S_MOD: begin
          if (r_q >= {1'b0, wid_q}) begin
            r_q <= r_q - {1'b0, wid_q};
          end else begin
            if (r_q != 7'd0) tail_q <= tail_q + 12'({1'b0, wid_q} - r_q);
            if (e_q == 8'hFF) begin
              p_q <= '0; row_q <= '0; col_q <= '0;
              state_q <= S_SCT_RD;
            end else begin
              e_q     <= e_q + 8'd1;
              state_q <= S_PFX_RD;
            end
          end
        end
        S_SCT_RD:  state_q <= S_SCT_CUR;
        S_SCT_CUR: begin
          e_q     <= pair_rd[7:0];
          state_q <= S_SCT_WR;
        end
        S_SCT_WR: begin
          if (col_q + 9'd1 == cfg.per_row) begin
            col_q <= '0;
            row_q <= row_q + 6'd1;
          end else begin
            col_q <= col_q + 9'd1;
          end
          if (last_pair) begin
            k_q     <= '0;
            state_q <= S_EMT_SLOT;
          end else begin
            p_q     <= p_q + 7'd1;
            state_q <= S_SCT_RD;
          end
        end
        S_EMT_SLOT: state_q <= S_EMT_PAIR;
        S_EMT_PAIR: begin
          p_q     <= {1'b0, slot_rd[5:0]};
          row_q   <= slot_rd[11:6];
          state_q <= S_EMT_BKT;
        end
        S_EMT_BKT: begin
          e_q     <= pair_rd[7:0];
          w_q     <= pair_rd[39:8];
          state_q <= S_EMT_OUT;
        end
        S_EMT_OUT: begin
          if (!out_vld_q) begin
            out_vld_q <= 1'b1;
            out_q     <= '{status: ST_OK, expert: e_q, start: 6'(cur_rd - popv),
                           pop: popv, pair: p_q[5:0], row: row_q, weight: w_q,
                           last: last_emit,
                           bcnt: last_emit ? bcnt_q : 7'd0,
                           maxp: last_emit ? maxp_q : 7'd0,
                           elig: last_emit ? elig_q : 7'd0,
                           tail: last_emit ? tail_q : 12'd0};
            if (last_emit) begin
              pl_q      <= '0;
              err_q     <= 1'b0;
              pop_vld_q <= '0;
              state_q   <= S_IDLE;
            end else begin
              k_q     <= k_q + 7'd1;
              state_q <= S_EMT_SLOT;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {4'd0, out_q.tail, out_q.elig, out_q.maxp, out_q.bcnt,
                          out_q.weight, out_q.row, out_q.pair, out_q.pop,
                          out_q.start, out_q.expert, out_q.status};

`include "expert_major_pair_bucketing_top_assert.svh"

  `EMP_ASSERT_NXT(a_cfg_error, clk_i, rst_ni, s_acc && !cfg.valid, m_axis_tvalid && out_q.status == ST_CFG && out_q.last, "bad config must give an error result")
  `EMP_ASSERT_IMP(a_busy, clk_i, rst_ni, state_q != S_IDLE, !s_axis_tready, "input taken while sorting")
  `EMP_ASSERT_IMP(a_load_bound, clk_i, rst_ni, state_q == S_IDLE, pl_q < 7'(MAX_PAIRS), "pair count overflow while loading")
  `EMP_ASSERT_IMP(a_emit_bound, clk_i, rst_ni, state_q == S_EMT_OUT, k_q < n_q, "emit index past pair count")

endmodule

[bench/tb_top.sv]
// testbench of the expert-major pair bucketing block: streams routed pairs,
// predicts the bucketed list and compares every result; depends on emp_pkg
`timescale 1ns / 1ps
module tb_top;
  import emp_pkg::*;

  localparam int LIMIT = 20000;

  typedef struct packed {
    logic [11:0] tail;
    logic [6:0]  elig;
    logic [6:0]  maxp;
    logic [6:0]  bcnt;
    logic [31:0] weight;
    logic [5:0]  row;
    logic [5:0]  pair;
    logic [6:0]  pop;
    logic [5:0]  start;
    logic [7:0]  expert;
    logic [1:0]  status;
  } bucket_res_t;

  typedef struct {
    bucket_res_t res;
    logic        last;
  } bucket_exp_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;   // expert_index, route_weight
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;        // status ... pad_rows, zero pad
  logic         m_axis_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [5:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  expert_major_pair_bucketing_top u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the registers and run state
  logic [8:0]  cfg_experts;
  logic [8:0]  cfg_per_row;
  logic [5:0]  cfg_rows;
  logic [62:0] cfg_widths;
  logic [5:0]  cfg_tc_min;
  logic [7:0]  pair_expert [MAX_PAIRS];
  logic [31:0] pair_weight [MAX_PAIRS];
  int          pairs_in;
  bit          pair_bad;

  bucket_exp_t bucket_q[$];
  int          fail_count = 0;
  bit          idle_on = 1'b1;
  int          hold_req = 0;
  int          quiet_cycles = 0;

  function automatic bit cfg_ok();
    if (cfg_experts < 1 || cfg_experts > MAX_EXPERTS) return 0;
    if (cfg_per_row < 1 || cfg_per_row > cfg_experts) return 0;
    if (cfg_rows < 1 || cfg_rows >= 63) return 0;
    if (!cfg_widths[1] || cfg_widths[0]) return 0;
    if (!cfg_widths[cfg_rows]) return 0;
    if (cfg_tc_min != 0 && (cfg_tc_min >= 63 || !cfg_widths[cfg_tc_min])) return 0;
    if (int'(cfg_rows) * int'(cfg_per_row) > MAX_PAIRS) return 0;
    return 1;
  endfunction

  task automatic push_error(input logic [1:0] st);
    bucket_exp_t x;
    x.res = '0;
    x.res.status = st;
    x.last = 1'b1;
    bucket_q.push_back(x);
    pairs_in = 0;
    pair_bad = 0;
  endtask

  task automatic predict_pair(input logic [7:0] e, input logic [31:0] w);
    int total, n, width, cursor, buckets, maxpop, eligible, tail;
    int pop [MAX_EXPERTS];
    int start [MAX_EXPERTS];
    bucket_exp_t x;
    if (!cfg_ok()) begin
      push_error(ST_CFG);
      return;
    end
    total = int'(cfg_rows) * int'(cfg_per_row);
    if (pairs_in < MAX_PAIRS) begin
      pair_expert[pairs_in] = e;
      pair_weight[pairs_in] = w;
      pairs_in++;
    end
    if (e >= cfg_experts || w[30:23] == 8'hff) pair_bad = 1;
    if (pairs_in < total) return;
    if (pair_bad) begin
      push_error(ST_PAIR);
      return;
    end
    n = pairs_in;
    width = 0;
    for (int b = 1; b < 63; b++) if (cfg_widths[b]) width = b;
    foreach (pop[i]) pop[i] = 0;
    for (int p = 0; p < n; p++) pop[pair_expert[p]]++;
    cursor = 0; buckets = 0; maxpop = 0; eligible = 0; tail = 0;
    for (int i = 0; i < MAX_EXPERTS; i++) begin
      start[i] = cursor;
      cursor += pop[i];
      if (pop[i] != 0) begin
        buckets++;
        if (pop[i] > maxpop) maxpop = pop[i];
        if (cfg_tc_min != 0 && pop[i] >= cfg_tc_min) begin
          eligible += pop[i];
          if (width != 0 && pop[i] % width != 0) tail += width - pop[i] % width;
        end
      end
    end
    for (int i = 0; i < MAX_EXPERTS; i++) begin
      for (int p = 0; p < n; p++) begin
        if (pop[i] != 0 && pair_expert[p] == i) begin
          x.res = '0;
          x.res.status = ST_OK;
          x.res.expert = i[7:0];
          x.res.start = start[i][5:0];
          x.res.pop = pop[i][6:0];
          x.res.pair = p[5:0];
          x.res.row = 6'(p / int'(cfg_per_row));
          x.res.weight = pair_weight[p];
          x.last = 1'b0;
          bucket_q.push_back(x);
        end
      end
    end
    bucket_q[$].last = 1'b1;
    bucket_q[$].res.bcnt = buckets[6:0];
    bucket_q[$].res.maxp = maxpop[6:0];
    bucket_q[$].res.elig = eligible[6:0];
    bucket_q[$].res.tail = tail[11:0];
    pairs_in = 0;
    pair_bad = 0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    bucket_exp_t x;
    bucket_res_t r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      r = bucket_res_t'(m_axis_tdata[99:0]);
      if (bucket_q.size() == 0) begin
        $display("%0t unexpected result expected none actual %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        x = bucket_q.pop_front();
        check_field("status", 32'(x.res.status), 32'(r.status));
        check_field("expert_id", 32'(x.res.expert), 32'(r.expert));
        check_field("bucket_start", 32'(x.res.start), 32'(r.start));
        check_field("bucket_population", 32'(x.res.pop), 32'(r.pop));
        check_field("source_pair", 32'(x.res.pair), 32'(r.pair));
        check_field("token_row", 32'(x.res.row), 32'(r.row));
        check_field("pair_weight", x.res.weight, r.weight);
        check_field("last", 32'(x.last), 32'(m_axis_tlast));
        check_field("nonempty_buckets", 32'(x.res.bcnt), 32'(r.bcnt));
        check_field("max_population", 32'(x.res.maxp), 32'(r.maxp));
        check_field("eligible_pairs", 32'(x.res.elig), 32'(r.elig));
        check_field("pad_rows", 32'(x.res.tail), 32'(r.tail));
        check_field("pad", 32'd0, 32'(m_axis_tdata[103:100]));
      end
    end
  end

  // receiver with random stalls and the long hold-off
  always @(negedge clk_i) begin
    int burst;
    if (hold_req > 0) begin
      m_axis_tready <= 1'b0;
      hold_req--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      burst = $urandom_range(1, 8);
      repeat (burst - 1) @(negedge clk_i);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_EXPERT_COUNT:    cfg_experts = value[8:0];
      REG_EXPERTS_PER_ROW: cfg_per_row = value[8:0];
      REG_ROW_COUNT:       cfg_rows = value[5:0];
      REG_WIDTH_MASK:      cfg_widths = value[62:0];
      REG_TC_MINIMUM:      cfg_tc_min = value[5:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (bucket_q.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_pair(input logic [7:0] e, input logic [31:0] w);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {w, e};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pair(e, w);
  endtask

  task automatic apply_cfg(input logic [8:0] ec, input logic [8:0] epr, input logic [5:0] rc,
                           input logic [62:0] wm, input logic [5:0] tcm);
    wait_idle();
    write_reg(REG_EXPERT_COUNT, {$urandom, 23'($urandom), ec});
    write_reg(REG_EXPERTS_PER_ROW, {$urandom, 23'($urandom), epr});
    write_reg(REG_ROW_COUNT, {$urandom, 26'($urandom), rc});
    write_reg(REG_WIDTH_MASK, {$urandom_range(0, 1) == 1'b1, wm});
    write_reg(REG_TC_MINIMUM, {$urandom, 26'($urandom), tcm});
  endtask

  function automatic logic [31:0] finite_weight();
    logic [31:0] w;
    w = $urandom;
    if (w[30:23] == 8'hff) w[23] = 1'b0;
    return w;
  endfunction

  task automatic test_reset_defaults();
    send_pair(8'd0, 32'h3f80_0000);
    send_pair(8'd1, 32'h3f80_0000);
    send_pair(8'd0, 32'h7f80_0000);
    send_pair(8'd0, 32'hff7f_ffff);
  endtask

  task automatic test_bad_config();
    apply_cfg(9'd0, 9'd1, 6'd1, 63'h2, 6'd0);
    send_pair(8'd0, 32'h0);
    send_pair(8'd3, 32'h1234_5678);
    apply_cfg(9'd300, 9'd1, 6'd1, 63'h2, 6'd0);
    send_pair(8'd0, 32'h0);
    apply_cfg(9'd8, 9'd8, 6'd9, {63{1'b1}} & ~63'h1, 6'd0);
    send_pair(8'd1, 32'h0);
    wait_idle();
    write_reg(3'd5, 64'h0);
    write_reg(3'd7, {64{1'b1}});
  endtask

  task automatic test_buckets_and_tail();
    apply_cfg(9'd4, 9'd2, 6'd4, 63'h1_001e, 6'd2);
    send_pair(8'd3, 32'h0000_0001);
    send_pair(8'd1, 32'h8000_0000);
    send_pair(8'd3, 32'h7f7f_ffff);
    send_pair(8'd0, 32'h4000_0000);
    send_pair(8'd3, 32'h0000_0000);
    send_pair(8'd1, 32'hbf80_0000);
    send_pair(8'd3, 32'hffff_ffff & 32'hff7f_ffff);
    send_pair(8'd2, 32'h0055_aa55);
    // rows shrink while pairs are loaded: the run closes early
    apply_cfg(9'd4, 9'd1, 6'd4, 63'h1e, 6'd0);
    send_pair(8'd2, 32'h1);
    send_pair(8'd2, 32'h2);
    wait_idle();
    write_reg(REG_ROW_COUNT, 64'd2);
    send_pair(8'd0, 32'h3);
  endtask

  task automatic random_cfg(input bit extreme, input bit broken);
    int ec, epr, rc, maxr, j;
    logic [62:0] wm;
    logic [5:0] tcm;
    if (extreme) ec = 256;
    else case ($urandom_range(0, 3))
      0: ec = $urandom_range(1, 256);
      default: ec = $urandom_range(1, 12);
    endcase
    epr = $urandom_range(1, (ec < 64) ? ec : 64);
    if (extreme && $urandom_range(0, 1)) epr = 1;
    maxr = 64 / epr;
    if (maxr > 62) maxr = 62;
    rc = extreme ? maxr : $urandom_range(1, (maxr < 6) ? maxr : 6);
    wm = 63'({$urandom, $urandom});
    if (extreme) wm = '1;
    wm[0] = 1'b0;
    wm[1] = 1'b1;
    wm[rc] = 1'b1;
    tcm = 6'd0;
    if (extreme) tcm = 6'd62;
    else if ($urandom_range(0, 2) != 0) begin
      j = $urandom_range(1, 8);
      wm[j] = 1'b1;
      tcm = j[5:0];
    end
    if (broken) case ($urandom_range(0, 9))
      0: ec = 0;
      1: ec = $urandom_range(257, 511);
      2: epr = ec + 1;
      3: epr = 0;
      4: rc = 0;
      5: rc = 63;
      6: wm[1] = 1'b0;
      7: wm[0] = 1'b1;
      8: tcm = 6'd63;
      default: begin
        epr = 64;
        ec = 256;
        rc = 2;
        wm[2] = 1'b1;
      end
    endcase
    apply_cfg(ec[8:0], epr[8:0], rc[5:0], wm, tcm);
  endtask

  task automatic test_random_runs();
    int items, run, total, limit_e;
    bit broken, noisy;
    logic [7:0] e;
    logic [31:0] w;
    items = 0;
    run = 0;
    while (items < 420) begin
      broken = ($urandom_range(0, 9) == 0);
      // error results fill the output while the receiver holds off
      if (run == 6) broken = 1'b1;
      random_cfg((run % 9) == 4, broken);
      noisy = ($urandom_range(0, 5) == 0);
      if (items > 360) idle_on = 1'b0;
      if (run == 6) hold_req = 400;
      total = cfg_ok() ? int'(cfg_rows) * int'(cfg_per_row) :
              ((run == 6) ? 6 : $urandom_range(1, 3));
      limit_e = (cfg_experts == 0) ? 1 : int'(cfg_experts);
      if (limit_e > 256) limit_e = 256;
      for (int i = 0; i < total; i++) begin
        e = 8'($urandom_range(0, limit_e - 1));
        w = finite_weight();
        if (noisy && $urandom_range(0, 7) == 0) begin
          if ($urandom_range(0, 1)) e = 8'($urandom_range(0, 255));
          else w[30:23] = 8'hff;
        end
        send_pair(e, w);
        items++;
      end
      run++;
    end
  endtask

  initial begin
    cfg_experts = 9'd1;
    cfg_per_row = 9'd1;
    cfg_rows = 6'd1;
    cfg_widths = 63'd2;
    cfg_tc_min = 6'd0;
    pairs_in = 0;
    pair_bad = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_bad_config();
    test_buckets_and_tail();
    test_random_runs();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (bucket_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
